@@ sv/rohc_pkg.sv @@
// Shared constants, types and controller codes for the recency-ordered hot cache.
package rohc_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int STAMP_W = 31;
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int SLOT_W  = 6;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_FIND,
    ST_SORT,
    ST_WRITE,
    ST_FLOOR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_req;
    logic cmp;
    logic find;
    logic sort;
    logic write;
    logic floor;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic lookup;
    logic reject;
    logic out_free;
  } dp_status_t;

endpackage

@@ sv/rohc_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface rohc_req_if;
  import rohc_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [STAMP_W-1:0] stamp;
  logic [KEY_W-1:0]   short_key;
  logic [KEY_W-1:0]   full_key;
  logic [VAL_W-1:0]   new_value;

  modport source (output valid, action, stamp, short_key, full_key, new_value,
                  input ready);
  modport sink   (input valid, action, stamp, short_key, full_key, new_value,
                  output ready);
endinterface

interface rohc_rsp_if;
  import rohc_pkg::*;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [VAL_W-1:0]  read_value;
  logic [SLOT_W-1:0] final_slot;

  modport source (output valid, ok, read_value, final_slot, input ready);
  modport sink   (input valid, ok, read_value, final_slot, output ready);
endinterface

@@ sv/rohc_ctrl.sv @@
// Controller state machine sequencing match, sort, write and response steps.
module rohc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rohc_pkg::dp_status_t status_i,
  output rohc_pkg::dp_cmd_t    cmd_o
);
  import rohc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_FIND;
      end
      ST_FIND: begin
        cmd_o.find = 1'b1;
        state_d    = ST_SORT;
      end
      ST_SORT: begin
        cmd_o.sort = 1'b1;
        state_d    = (status_i.lookup || status_i.reject) ? ST_DONE : ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_FLOOR;
      end
      ST_FLOOR: begin
        cmd_o.floor = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/rohc_dp.sv @@
// Datapath: entry cell chain with parallel key match, sorted shift and response register.
module rohc_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rohc_pkg::dp_cmd_t         cmd_i,
  output rohc_pkg::dp_status_t      status_o,
  input  logic                      req_action_i,
  input  logic [rohc_pkg::STAMP_W-1:0] req_stamp_i,
  input  logic [rohc_pkg::KEY_W-1:0]   req_short_key_i,
  input  logic [rohc_pkg::KEY_W-1:0]   req_full_key_i,
  input  logic [rohc_pkg::VAL_W-1:0]   req_new_value_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic                      out_ok_o,
  output logic [rohc_pkg::VAL_W-1:0]   out_read_value_o,
  output logic [rohc_pkg::SLOT_W-1:0]  out_final_slot_o
);
  import rohc_pkg::*;

  // entry cells
  logic [KEY_W-1:0]   sk_q  [ENTRIES];
  logic [STAMP_W-1:0] st_q  [ENTRIES];
  logic [KEY_W-1:0]   fk_q  [ENTRIES];
  logic [VAL_W-1:0]   val_q [ENTRIES];

  logic [CNT_W-1:0]   count_q;
  logic [STAMP_W-1:0] floor_q;

  // request
  logic               act_q;
  logic [STAMP_W-1:0] rst_stamp_q;
  logic [KEY_W-1:0]   rsk_q;
  logic [KEY_W-1:0]   rfk_q;
  logic [VAL_W-1:0]   rval_q;

  // pipeline of the step
  logic [ENTRIES-1:0] match_q, ge_q;
  logic               reject_q;
  logic [ENTRIES-1:0] hit_oh_q, hit_oh_d;
  logic               hit_q, hit_d;
  logic [IDX_W-1:0]   pos_q, pos_d, hit_idx;
  logic [IDX_W-1:0]   newpos_q, newpos_d;
  logic               lk_ok_q, lk_ok_d;
  logic [VAL_W-1:0]   lk_val_q, lk_val_d;
  logic [KEY_W-1:0]   sel_fk;
  logic [VAL_W-1:0]   sel_val;
  logic [STAMP_W-1:0] last_st;
  logic [CNT_W-1:0]   last_cnt;

  // response register
  logic               out_valid_q;
  logic               out_ok_q;
  logic [VAL_W-1:0]   out_val_q;
  logic [SLOT_W-1:0]  out_slot_q;

  assign status_o.lookup   = (act_q == ACT_LOOKUP);
  assign status_o.reject   = reject_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      act_q       <= req_action_i;
      rst_stamp_q <= req_stamp_i;
      rsk_q       <= req_short_key_i;
      rfk_q       <= req_full_key_i;
      rval_q      <= req_new_value_i;
    end
  end

  // per-cell compares
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      for (int k = 0; k < ENTRIES; k++) begin
        match_q[k] <= (CNT_W'(k) < count_q) && (sk_q[k] == rsk_q);
        ge_q[k]    <= (st_q[k] >= rst_stamp_q);
      end
      reject_q <= (rst_stamp_q <= floor_q);
    end
  end

  // first match and target slot
  always_comb begin
    hit_oh_d = '0;
    hit_d    = 1'b0;
    hit_idx  = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (match_q[k]) begin
        hit_oh_d    = '0;
        hit_oh_d[k] = 1'b1;
        hit_d       = 1'b1;
        hit_idx     = IDX_W'(k);
      end
    end
    if (hit_d) begin
      pos_d = hit_idx;
    end else if (count_q >= CNT_W'(ENTRIES)) begin
      pos_d = IDX_W'(ENTRIES - 1);
    end else begin
      pos_d = count_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.find) begin
      hit_oh_q <= hit_oh_d;
      hit_q    <= hit_d;
      pos_q    <= pos_d;
    end
  end

  // insertion point and lookup result
  always_comb begin
    newpos_d = '0;
    sel_fk   = '0;
    sel_val  = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (ge_q[k] && (IDX_W'(k) < pos_q)) begin
        newpos_d = IDX_W'(k + 1);
      end
      if (hit_oh_q[k]) begin
        sel_fk  = sel_fk | fk_q[k];
        sel_val = sel_val | val_q[k];
      end
    end
    lk_ok_d  = hit_q && (sel_fk == rfk_q);
    lk_val_d = lk_ok_d ? sel_val : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sort) begin
      newpos_q <= newpos_d;
      lk_ok_q  <= lk_ok_d;
      lk_val_q <= lk_val_d;
    end
  end

  // cell chain update
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (cmd_i.write && (newpos_q == IDX_W'(g))) begin
          sk_q[g]  <= rsk_q;
          st_q[g]  <= rst_stamp_q;
          fk_q[g]  <= rfk_q;
          val_q[g] <= rval_q;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (cmd_i.write) begin
          if (newpos_q == IDX_W'(g)) begin
            sk_q[g]  <= rsk_q;
            st_q[g]  <= rst_stamp_q;
            fk_q[g]  <= rfk_q;
            val_q[g] <= rval_q;
          end else if ((IDX_W'(g) > newpos_q) && (IDX_W'(g) <= pos_q)) begin
            sk_q[g]  <= sk_q[g-1];
            st_q[g]  <= st_q[g-1];
            fk_q[g]  <= fk_q[g-1];
            val_q[g] <= val_q[g-1];
          end
        end
      end
    end
  end

  // stamp of the last occupied cell
  assign last_cnt = count_q - CNT_W'(1);
  always_comb begin
    last_st = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (CNT_W'(k) == last_cnt) begin
        last_st = last_st | st_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      floor_q <= '0;
    end else begin
      if (cmd_i.write && !hit_q && (count_q < CNT_W'(ENTRIES))) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.floor) begin
        floor_q <= last_st;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (act_q == ACT_LOOKUP) begin
        out_ok_q   <= lk_ok_q;
        out_val_q  <= lk_val_q;
        out_slot_q <= lk_ok_q ? SLOT_W'(pos_q) : '0;
      end else if (reject_q) begin
        out_ok_q   <= 1'b0;
        out_val_q  <= '0;
        out_slot_q <= '0;
      end else begin
        out_ok_q   <= 1'b1;
        out_val_q  <= '0;
        out_slot_q <= SLOT_W'(newpos_q);
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_ok_o         = out_ok_q;
  assign out_read_value_o = out_val_q;
  assign out_final_slot_o = out_slot_q;

endmodule

@@ sv/recency_ordered_hot_cache.sv @@
// Top level of the recency-ordered hot cache.
// Sequence: after the request transfer, lookups and rejected inserts pass the compare,
// find and sort steps before the response register is loaded; accepted inserts add the
// write (cell shift) and floor update steps. The single-request controller takes no new
// request until the last one's response is loaded, and waits while that register holds an untaken response.
// Reset: asynchronous, empties the cache (count and floor to zero); no clearing pass.
module recency_ordered_hot_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  rohc_req_if.sink    req_i,
  rohc_rsp_if.source  rsp_o
);
  import rohc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rohc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rohc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .req_action_i     (req_i.action),
    .req_stamp_i      (req_i.stamp),
    .req_short_key_i  (req_i.short_key),
    .req_full_key_i   (req_i.full_key),
    .req_new_value_i  (req_i.new_value),
    .out_ready_i      (rsp_o.ready),
    .out_valid_o      (rsp_o.valid),
    .out_ok_o         (rsp_o.ok),
    .out_read_value_o (rsp_o.read_value),
    .out_final_slot_o (rsp_o.final_slot)
  );

endmodule

@@ sv/rohc_checker.sv @@
// Port-level checker for the hot cache, bound to the top level.
module rohc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         out_ok_i,
  input logic [rohc_pkg::VAL_W-1:0]   out_read_value_i,
  input logic [rohc_pkg::SLOT_W-1:0]  out_final_slot_i
);
  import rohc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response dropped before transfer");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while previous one in progress");

  a_value_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_read_value_i != '0) |-> out_ok_i)
    else $error("nonzero read value on failed response");

  a_slot_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ok_i |-> (out_final_slot_i == '0))
    else $error("nonzero slot on failed response");

endmodule

bind recency_ordered_hot_cache rohc_checker u_rohc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .out_ok_i         (rsp_o.ok),
  .out_read_value_i (rsp_o.read_value),
  .out_final_slot_i (rsp_o.final_slot)
);
